>>> hdl/lsrc_pkg.sv
// Package for the laser stripe row centroid block: widths, defaults, shared types.
// No dependencies.
`timescale 1ns / 1ps
package lsrc_pkg;
    localparam int unsigned MAX_COLUMNS_DEF   = 1024;
    localparam int unsigned MAX_ROWS_DEF      = 1024;
    localparam int unsigned PIXEL_BITS_DEF    = 8;
    localparam int unsigned FRACTION_BITS_DEF = 8;
    localparam int unsigned THR_BITS          = 8;
    localparam int unsigned ROW_OUT_BITS      = 10;
    localparam int unsigned CENTER_OUT_BITS   = 18;
    localparam logic [THR_BITS-1:0] THR_RESET = 8'd26;

    typedef struct packed {
        logic load;      // store pixel word
        logic row_end;   // clear row trackers
        logic walk_init; // load accumulators from peak
        logic rd_left;   // issue left read
        logic rd_right;  // issue right read
        logic acc_left;  // evaluate left read data
        logic acc_right; // evaluate right read data
        logic div_start;
    } t_cmd;

    typedef struct packed {
        logic peak_zero;
        logic left_end;   // left walk may not continue
        logic right_end;
        logic joined;     // last evaluated pixel joined
        logic div_done;
    } t_sts;
endpackage

>>> hdl/lsrc_if.sv
// Valid/ready channel interface carrying a packed payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface lsrc_if #(parameter int unsigned W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/lsrc_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module lsrc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

>>> hdl/lsrc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module lsrc_div #(
    parameter int unsigned NW = 36,
    parameter int unsigned DW = 22
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int unsigned CW = $clog2(NW + 1);
    logic [NW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [DW:0]   w_sh;

    always_comb begin
        w_sh  = {r_rem[DW-1:0], r_q[NW-1]};
        n_q   = {r_q[NW-2:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem  = w_sh - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end
    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

>>> hdl/lsrc_datapath.sv
// Datapath: line store, peak tracking, walk accumulators, row counter, divider.
// Depends on lsrc_pkg, lsrc_ram, lsrc_div.
`timescale 1ns / 1ps
module lsrc_datapath import lsrc_pkg::*; #(
    parameter int unsigned MAX_COLUMNS   = MAX_COLUMNS_DEF,
    parameter int unsigned MAX_ROWS      = MAX_ROWS_DEF,
    parameter int unsigned PIXEL_BITS    = PIXEL_BITS_DEF,
    parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    input  logic [PIXEL_BITS-1:0]      i_pixel,
    input  logic                       i_frame_last,
    input  logic [THR_BITS-1:0]        i_thr,
    output logic [ROW_OUT_BITS-1:0]    o_row,
    output logic [CENTER_OUT_BITS-1:0] o_center
);
    localparam int unsigned AW  = $clog2(MAX_COLUMNS);
    localparam int unsigned CCW = $clog2(MAX_COLUMNS + 1);
    localparam int unsigned RW  = $clog2(MAX_ROWS) > 0 ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned SW  = PIXEL_BITS + CCW;
    localparam int unsigned WW  = PIXEL_BITS + 2 * AW;
    localparam int unsigned NW  = WW + FRACTION_BITS;
    localparam int unsigned LW  = PIXEL_BITS + THR_BITS;

    logic [CCW-1:0]        r_cnt;
    logic [PIXEL_BITS-1:0] r_peak;
    logic [AW-1:0]         r_peak_col;
    logic [RW-1:0]         r_row, r_row_hold;
    logic                  r_fl;       // frame flag of the last loaded word
    logic [CCW-1:0]        r_len;
    logic [LW-1:0]         r_limit;
    logic [SW-1:0]         r_s;
    logic [WW-1:0]         r_w;
    logic [AW-1:0]         r_l, r_r;   // next column to evaluate
    logic                  r_ldone, r_rdone, r_joined;
    logic [PIXEL_BITS-1:0] w_rdata;
    logic [AW-1:0]         w_raddr;
    logic                  w_join;
    logic [NW-1:0]         w_quot;
    logic                  w_we;

    assign w_we    = i_cmd.load && (r_cnt < CCW'(MAX_COLUMNS));
    assign w_raddr = i_cmd.rd_left ? r_l : r_r;

    lsrc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLUMNS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_cnt[AW-1:0]),
        .i_wdata(i_pixel),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_join = {w_rdata, 8'd0} >= (PIXEL_BITS + 8)'(r_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_peak     <= '0;
            r_peak_col <= '0;
            r_row      <= '0;
            r_fl       <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_fl <= i_frame_last;
            end
            if (w_we) begin
                r_cnt <= r_cnt + 1'b1;
                if (i_pixel > r_peak) begin
                    r_peak     <= i_pixel;
                    r_peak_col <= r_cnt[AW-1:0];
                end
            end
            if (i_cmd.row_end) begin
                r_cnt      <= '0;
                r_peak     <= '0;
                r_peak_col <= '0;
                if (r_fl) begin
                    r_row <= '0;
                end else if (r_row < RW'(MAX_ROWS - 1)) begin
                    r_row <= r_row + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_limit    <= LW'(i_thr * r_peak);
            r_s        <= SW'(r_peak);
            r_w        <= WW'(r_peak * r_peak_col);
            r_len      <= r_cnt;
            r_row_hold <= r_row;
            r_l        <= r_peak_col - 1'b1;
            r_r        <= r_peak_col + 1'b1;
            r_ldone    <= (r_peak_col == '0);
            r_rdone    <= (CCW'(r_peak_col) + 1'b1 >= r_cnt);
        end
        if (i_cmd.acc_left) begin
            r_joined <= w_join;
            if (w_join) begin
                r_s <= r_s + SW'(w_rdata);
                r_w <= r_w + WW'(w_rdata * r_l);
                r_l <= r_l - 1'b1;
                if (r_l == '0) begin
                    r_ldone <= 1'b1;
                end
            end else begin
                r_ldone <= 1'b1;
            end
        end
        if (i_cmd.acc_right) begin
            r_joined <= w_join;
            if (w_join) begin
                r_s <= r_s + SW'(w_rdata);
                r_w <= r_w + WW'(w_rdata * r_r);
                r_r <= r_r + 1'b1;
                if (CCW'(r_r) + 1'b1 >= r_len) begin
                    r_rdone <= 1'b1;
                end
            end else begin
                r_rdone <= 1'b1;
            end
        end
    end

    lsrc_div #(.NW(NW), .DW(SW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  ({r_w, {FRACTION_BITS{1'b0}}}),
        .i_den  (r_s),
        .o_done (o_sts.div_done),
        .o_quot (w_quot)
    );

    assign o_sts.peak_zero = (r_peak == '0);
    assign o_sts.left_end  = r_ldone;
    assign o_sts.right_end = r_rdone;
    assign o_sts.joined    = r_joined;
    assign o_row    = ROW_OUT_BITS'(r_row_hold);
    assign o_center = CENTER_OUT_BITS'(w_quot);
endmodule

>>> hdl/lsrc_ctrl.sv
// Controller: sequences load, left/right walks, divide and result word.
// Depends on lsrc_pkg.
`timescale 1ns / 1ps
module lsrc_ctrl import lsrc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_row_last,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_INIT  = 8'b0000_0010,
        S_LRD   = 8'b0000_0100,
        S_LACC  = 8'b0000_1000,
        S_RRD   = 8'b0001_0000,
        S_RACC  = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   w_acc;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_OUT);
    assign w_acc       = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd           = '0;
        n_state         = r_state;
        o_cmd.load      = w_acc;
        case (r_state)
            S_LOAD: begin
                if (w_acc && i_row_last) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.row_end = 1'b1;
                if (i_sts.peak_zero) begin
                    n_state = S_LOAD;
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state = S_LRD;
                end
            end
            S_LRD: begin
                if (i_sts.left_end) begin
                    n_state = S_RRD;
                end else begin
                    o_cmd.rd_left = 1'b1;
                    n_state = S_LACC;
                end
            end
            S_LACC: begin
                o_cmd.acc_left = 1'b1;
                n_state = S_LRD;
            end
            S_RRD: begin
                if (i_sts.right_end) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.rd_right = 1'b1;
                    n_state = S_RACC;
                end
            end
            S_RACC: begin
                o_cmd.acc_right = 1'b1;
                n_state = S_RRD;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

>>> hdl/laser_stripe_row_centroid_top.sv
// Laser stripe row centroid. Pixels load one per cycle; after the last pixel of a row
// the block walks left, then right: a read and an evaluate state per examined pixel
// (joined ones plus at most one stop pixel per side), then a 36-bit restoring divide
// and one result word. Input stalls meanwhile.
// Synchronous active-low reset; threshold resets to 26; line store is not cleared.
`timescale 1ns / 1ps
module laser_stripe_row_centroid_top import lsrc_pkg::*; #(
    parameter int unsigned MAX_COLUMNS   = MAX_COLUMNS_DEF,
    parameter int unsigned MAX_ROWS      = MAX_ROWS_DEF,
    parameter int unsigned PIXEL_BITS    = PIXEL_BITS_DEF,
    parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    lsrc_if.sink                    in_ch,
    lsrc_if.source                  out_ch,
    lsrc_if.sink                    cfg_ch
);
    // in_ch.data = {pixel_value, row_last, frame_last}
    // out_ch.data = {row_number, center_column_q8}
    t_cmd                  w_cmd;
    t_sts                  w_sts;
    logic [THR_BITS-1:0]   r_thr;
    logic [PIXEL_BITS-1:0] w_pixel;

    assign w_pixel      = in_ch.data[PIXEL_BITS+1:2];
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (cfg_ch.valid) begin
            r_thr <= cfg_ch.data[THR_BITS-1:0];
        end
    end

    lsrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_row_last (in_ch.data[1]),
        .o_in_ready (in_ch.ready),
        .i_out_ready(out_ch.ready),
        .o_out_valid(out_ch.valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lsrc_datapath #(
        .MAX_COLUMNS  (MAX_COLUMNS),
        .MAX_ROWS     (MAX_ROWS),
        .PIXEL_BITS   (PIXEL_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_pixel     (w_pixel),
        .i_frame_last(in_ch.data[0]),
        .i_thr       (r_thr),
        .o_row       (out_ch.data[CENTER_OUT_BITS+ROW_OUT_BITS-1:CENTER_OUT_BITS]),
        .o_center    (out_ch.data[CENTER_OUT_BITS-1:0])
    );
endmodule
